// File: rtl/point_array_list_table_top_macros.svh
// ----------------------------------------------------------------------------
// Point list assertion macros
// Shared concurrent assertion forms for the point list RTL.
// ----------------------------------------------------------------------------
`ifndef POINT_ARRAY_LIST_TABLE_TOP_MACROS_SVH
`define POINT_ARRAY_LIST_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PAL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// Point list package
// Sizes, request and status codes, sequencer states and the store port type.
// ----------------------------------------------------------------------------
package pal_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int POS_W    = 7;
    localparam int COORD_W  = 32;
    localparam int ENTRY_W  = 2 * COORD_W;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_READ   = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_RESIZE = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_POS = 2'd1,
        STAT_CAP = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_FILL,
        S_RESP
    } state_t;

    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } mem_req_t;

endpackage

// File: rtl/point_array_list_table_top.sv
// ----------------------------------------------------------------------------
// Point list table
// Ordered list of up to 64 (x,y) points with append, insert, remove, read,
// clear and resize requests, one result transaction per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. Append, read, clear, shrinking resize,
// insert at the end, remove of the last entry and every rejected request
// go from acceptance straight to the result. Insert at pos moves count - pos
// entries and then writes the new point; remove at pos moves count - pos - 1
// entries; a growing resize zero-fills new_count - count entries. The entry
// store has a single write port, so each moved or zeroed entry costs one
// write. The store has no reset; entries are always written before they can
// be read. A waiting result does not stall acceptance of the next request.
module point_array_list_table_top
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic [2:0]                          action,
    input  logic [pal_pkg::POS_W-1:0]           pos,
    input  logic signed [pal_pkg::COORD_W-1:0]  px,
    input  logic signed [pal_pkg::COORD_W-1:0]  py,
    input  logic [pal_pkg::CNT_W-1:0]           new_count,

    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic [1:0]                          status,
    output logic                                found,
    output logic signed [pal_pkg::COORD_W-1:0]  rx,
    output logic signed [pal_pkg::COORD_W-1:0]  ry,
    output logic [pal_pkg::CNT_W-1:0]           count
);

`include "point_array_list_table_top_macros.svh"

    pal_pkg::state_t                 state_reg, state_next;
    logic [pal_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [pal_pkg::ADDR_W-1:0]      idx_reg, idx_next;
    logic [pal_pkg::ADDR_W-1:0]      stop_reg, stop_next;
    logic                            dir_down_reg, dir_down_next;
    logic                            pend_reg, pend_next;
    logic [pal_pkg::ADDR_W-1:0]      pend_addr_reg, pend_addr_next;
    logic                            is_ins_reg, is_ins_next;
    logic [pal_pkg::ADDR_W-1:0]      pos_reg, pos_next;
    logic [pal_pkg::ENTRY_W-1:0]     pt_reg, pt_next;
    pal_pkg::status_t                stat_reg, stat_next;
    logic                            found_reg, found_next;

    logic                            rsp_valid_reg, rsp_valid_next;
    pal_pkg::status_t                rsp_status_reg, rsp_status_next;
    logic                            rsp_found_reg, rsp_found_next;
    logic [pal_pkg::COORD_W-1:0]     rsp_rx_reg, rsp_rx_next;
    logic [pal_pkg::COORD_W-1:0]     rsp_ry_reg, rsp_ry_next;
    logic [pal_pkg::CNT_W-1:0]       rsp_count_reg, rsp_count_next;

    pal_pkg::mem_req_t               mem_req;
    logic [pal_pkg::ENTRY_W-1:0]     rd_data;

    logic [pal_pkg::CNT_W-1:0]       cnt_m1;
    logic [pal_pkg::CNT_W-1:0]       pos_p1;
    logic [pal_pkg::CNT_W-1:0]       ncnt_m1;

    pal_store u_store
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign cnt_m1  = count_reg - 1'b1;
    assign pos_p1  = pos + 1'b1;
    assign ncnt_m1 = new_count - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pal_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        stop_reg       <= stop_next;
        dir_down_reg   <= dir_down_next;
        pend_addr_reg  <= pend_addr_next;
        is_ins_reg     <= is_ins_next;
        pos_reg        <= pos_next;
        pt_reg         <= pt_next;
        stat_reg       <= stat_next;
        found_reg      <= found_next;
        rsp_status_reg <= rsp_status_next;
        rsp_found_reg  <= rsp_found_next;
        rsp_rx_reg     <= rsp_rx_next;
        rsp_ry_reg     <= rsp_ry_next;
        rsp_count_reg  <= rsp_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        stop_next       = stop_reg;
        dir_down_next   = dir_down_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        is_ins_next     = is_ins_reg;
        pos_next        = pos_reg;
        pt_next         = pt_reg;
        stat_next       = stat_reg;
        found_next      = found_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_found_next  = rsp_found_reg;
        rsp_rx_next     = rsp_rx_reg;
        rsp_ry_next     = rsp_ry_reg;
        rsp_count_next  = rsp_count_reg;
        mem_req         = '0;
        req_stall       = (state_reg != pal_pkg::S_IDLE);

        // drop a result once taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            pal_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    stat_next   = pal_pkg::STAT_OK;
                    found_next  = 1'b0;
                    pend_next   = 1'b0;
                    is_ins_next = 1'b0;
                    pt_next     = {px, py};
                    pos_next    = pos[pal_pkg::ADDR_W-1:0];
                    state_next  = pal_pkg::S_RESP;
                    unique case (action)
                        pal_pkg::ACT_APPEND:
                        begin
                            if (count_reg >= pal_pkg::CAP_CNT)
                            begin
                                stat_next = pal_pkg::STAT_CAP;
                            end
                            else
                            begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = count_reg[pal_pkg::ADDR_W-1:0];
                                mem_req.wr_data = {px, py};
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        pal_pkg::ACT_INSERT:
                        begin
                            if (pos > count_reg)
                            begin
                                stat_next = pal_pkg::STAT_POS;
                            end
                            else if (count_reg >= pal_pkg::CAP_CNT)
                            begin
                                stat_next = pal_pkg::STAT_CAP;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                if (pos == count_reg)
                                begin
                                    mem_req.wr_en   = 1'b1;
                                    mem_req.wr_addr = pos[pal_pkg::ADDR_W-1:0];
                                    mem_req.wr_data = {px, py};
                                end
                                else
                                begin
                                    state_next    = pal_pkg::S_SHIFT;
                                    dir_down_next = 1'b1;
                                    is_ins_next   = 1'b1;
                                    idx_next      = cnt_m1[pal_pkg::ADDR_W-1:0];
                                    stop_next     = pos[pal_pkg::ADDR_W-1:0];
                                end
                            end
                        end
                        pal_pkg::ACT_REMOVE:
                        begin
                            if (pos >= count_reg)
                            begin
                                stat_next = pal_pkg::STAT_POS;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                if (pos_p1 < count_reg)
                                begin
                                    state_next    = pal_pkg::S_SHIFT;
                                    dir_down_next = 1'b0;
                                    idx_next      = pos_p1[pal_pkg::ADDR_W-1:0];
                                    stop_next     = cnt_m1[pal_pkg::ADDR_W-1:0];
                                end
                            end
                        end
                        pal_pkg::ACT_READ:
                        begin
                            if (pos >= count_reg)
                            begin
                                stat_next = pal_pkg::STAT_POS;
                            end
                            else
                            begin
                                found_next      = 1'b1;
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = pos[pal_pkg::ADDR_W-1:0];
                            end
                        end
                        pal_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        pal_pkg::ACT_RESIZE:
                        begin
                            if (new_count > pal_pkg::CAP_CNT)
                            begin
                                stat_next = pal_pkg::STAT_CAP;
                            end
                            else
                            begin
                                count_next = new_count;
                                if (new_count > count_reg)
                                begin
                                    state_next = pal_pkg::S_FILL;
                                    idx_next   = count_reg[pal_pkg::ADDR_W-1:0];
                                    stop_next  = ncnt_m1[pal_pkg::ADDR_W-1:0];
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pal_pkg::S_SHIFT:
            begin
                // read one entry, write back the one read in the previous cycle
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
                if (pend_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = pend_addr_reg;
                    mem_req.wr_data = rd_data;
                end
                pend_next      = 1'b1;
                pend_addr_next = dir_down_reg ? idx_reg + 1'b1 : idx_reg - 1'b1;
                if (idx_reg == stop_reg)
                begin
                    state_next = pal_pkg::S_DRAIN;
                end
                else
                begin
                    idx_next = dir_down_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                end
            end
            pal_pkg::S_DRAIN:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pend_addr_reg;
                mem_req.wr_data = rd_data;
                pend_next       = 1'b0;
                state_next      = is_ins_reg ? pal_pkg::S_PUT : pal_pkg::S_RESP;
            end
            pal_pkg::S_PUT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = pos_reg;
                mem_req.wr_data = pt_reg;
                state_next      = pal_pkg::S_RESP;
            end
            pal_pkg::S_FILL:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = '0;
                if (idx_reg == stop_reg)
                begin
                    state_next = pal_pkg::S_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            pal_pkg::S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = stat_reg;
                    rsp_found_next  = found_reg;
                    rsp_rx_next     = found_reg ? rd_data[pal_pkg::ENTRY_W-1:pal_pkg::COORD_W]
                                                : '0;
                    rsp_ry_next     = found_reg ? rd_data[pal_pkg::COORD_W-1:0] : '0;
                    rsp_count_next  = count_reg;
                    state_next      = pal_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pal_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = rsp_status_reg;
    assign found     = rsp_found_reg;
    assign rx        = rsp_rx_reg;
    assign ry        = rsp_ry_reg;
    assign count     = rsp_count_reg;

    `PAL_ASSERT_SAME(a_count_in_range, 1'b1, count_reg <= pal_pkg::CAP_CNT,
        "entry count above capacity")
    `PAL_ASSERT_SAME(a_no_same_entry, mem_req.wr_en && mem_req.rd_en,
        mem_req.wr_addr != mem_req.rd_addr, "read and write hit the same entry")
    `PAL_ASSERT_SAME(a_shift_down_bound, state_reg == pal_pkg::S_SHIFT && dir_down_reg,
        idx_reg >= stop_reg, "downward move ran past its stop")
    `PAL_ASSERT_SAME(a_shift_up_bound, state_reg == pal_pkg::S_SHIFT && !dir_down_reg,
        idx_reg <= stop_reg, "upward move ran past its stop")
    `PAL_ASSERT_NEXT(a_result_issued,
        state_reg == pal_pkg::S_RESP && (!rsp_valid_reg || !rsp_stall),
        rsp_valid && state_reg == pal_pkg::S_IDLE, "result not issued")

endmodule

// File: rtl/pal_store.sv
// ----------------------------------------------------------------------------
// Point list entry store
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module pal_store
(
    input  logic                         clk,
    input  pal_pkg::mem_req_t            req,
    output logic [pal_pkg::ENTRY_W-1:0]  rd_data
);

    logic [pal_pkg::ENTRY_W-1:0] mem [pal_pkg::CAPACITY];
    logic [pal_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
